@@ src/pre_pkg.sv @@
// Package for the plateau region extender: register map, field widths and
// reset values shared by the top level. No dependencies.
package pre_pkg;

  // Generic defaults for the top-level parameters
  localparam int unsigned MaxWindowDef = 32768;
  localparam int unsigned ScoreBitsDef = 16;

  // Configuration register widths and reset values
  localparam int unsigned ThrW        = 16;
  localparam int unsigned BasesW      = 13;
  localparam logic [ThrW-1:0]   ThrReset   = 16'd27853;
  localparam logic [BasesW-1:0] BasesReset = 13'd5;

  // APB port geometry
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned RegIdxW  = ApbAddrW - 2;

  // Register indexes (byte address is 4 * index)
  localparam logic [RegIdxW-1:0] RegDropThreshold = 1'd0;
  localparam logic [RegIdxW-1:0] RegDropBases     = 1'd1;

endpackage

@@ src/pre_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module pre_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/plateau_region_extender.sv @@
// Plateau region extender top level: window load, core average check and
// left/right expansion scans over the sample RAM. Uses pre_pkg and pre_ram.
//
// Samples stream in one beat per cycle while s_tready is high and are
// written to a sample RAM of MAX_WINDOW entries; beats past MAX_WINDOW are
// dropped but a tlast on them still closes the window. The beat with tlast
// starts the evaluation: s_tready stays low while a setup computes the core
// length (check state) and then the threshold product (multiply state), then
// a single RAM read port scans left of the core and then right of it, one
// stored sample per cycle. A window end keeps s_tready low until the result
// beat is loaded into the output register, which waits for that register to
// drain; a window without core skips the product and the scans. The result
// beat carries first and last plateau indices, both inclusive; no_core in
// tuser marks a window without seed samples. Registers: drop_threshold at
// byte address 0, drop_bases at byte address 4; write them only while idle.
module plateau_region_extender #(
  parameter int unsigned MAX_WINDOW = pre_pkg::MaxWindowDef,
  parameter int unsigned SCORE_BITS = pre_pkg::ScoreBitsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // APB configuration port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [pre_pkg::ApbAddrW-1:0]                 paddr,
  input  logic [pre_pkg::ApbDataW-1:0]                 pwdata,
  output logic [pre_pkg::ApbDataW-1:0]                 prdata,
  output logic                                         pready,
  // Sample stream in
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((SCORE_BITS+7)/8)*8-1:0]              s_tdata,  // score
  input  logic [1:0]                                   s_tuser,  // missing, in_core
  input  logic                                         s_tlast,  // last_sample
  // Result stream out
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [((2*$clog2(MAX_WINDOW)+7)/8)*8-1:0]    m_tdata,  // plateau_first, plateau_last
  output logic [1:0]                                   m_tuser   // core_below_threshold, no_core
);
  import pre_pkg::*;

  localparam int unsigned IdxW    = $clog2(MAX_WINDOW);
  localparam int unsigned CntW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LenW    = IdxW + 1;
  localparam int unsigned SumW    = SCORE_BITS + IdxW;
  localparam int unsigned ProdW   = ThrW + LenW;
  localparam int unsigned CmpW    = (SumW > ProdW) ? SumW : ProdW;
  localparam int unsigned DistW   = (IdxW > BasesW) ? IdxW : BasesW;
  localparam int unsigned ScmpW   = (SCORE_BITS > ThrW) ? SCORE_BITS : ThrW;
  localparam int unsigned EntW    = SCORE_BITS + 1;
  localparam int unsigned OutDataW = ((2*IdxW+7)/8)*8;

  // Sequencer states
  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StLeft  = 3'd3;
  localparam logic [2:0] StRight = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [ThrW-1:0]   thr_q;
  logic [BasesW-1:0] bases_q;

  // Window state
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   core_first_q, core_first_d;
  logic [IdxW-1:0]   core_last_q, core_last_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              seen_q, seen_d;

  // Evaluation datapath
  logic [LenW-1:0]   len_q, len_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [IdxW-1:0]   first_q, first_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [IdxW-1:0]   addr_q, addr_d;
  logic [IdxW-1:0]   pidx_q, pidx_d;
  logic              more_q, more_d;
  logic              pend_q, pend_d;

  // Output register
  logic              m_tvalid_q, m_tvalid_d;
  logic [IdxW-1:0]   out_first_q, out_first_d;
  logic [IdxW-1:0]   out_last_q, out_last_d;
  logic [1:0]        out_user_q, out_user_d;

  // RAM signals
  logic              ram_we;
  logic [EntW-1:0]   ram_rdata;

  // Beat fields
  logic [SCORE_BITS-1:0] in_score;
  logic                  in_missing, in_core, in_beat;

  // Scan evaluation
  logic              ent_fail, stop_hit, scan_done, slot_free;
  logic [DistW-1:0]  gap_len;

  logic              cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  // ---------------------------------------------------------------------
  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      bases_q <= BasesReset;
    end else if (cfg_wr) begin
      if (cfg_idx == RegDropThreshold) begin
        thr_q <= pwdata[ThrW-1:0];
      end
      if (cfg_idx == RegDropBases) begin
        bases_q <= pwdata[BasesW-1:0];
      end
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (cfg_idx)
      RegDropThreshold: prdata = ApbDataW'(thr_q);
      RegDropBases:     prdata = ApbDataW'(bases_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stream fields
  assign in_score   = s_tdata[SCORE_BITS-1:0];
  assign in_missing = s_tuser[0];
  assign in_core    = s_tuser[1];
  assign s_tready   = (state_q == StLoad);
  assign in_beat    = s_tvalid & s_tready;
  assign ram_we     = in_beat & (cnt_q < CntW'(MAX_WINDOW));

  pre_ram #(
    .WIDTH(EntW),
    .DEPTH(MAX_WINDOW)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i({in_missing, in_score}),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Shared scan compare: fail test and distance to the outermost pass
  assign ent_fail = ram_rdata[SCORE_BITS] |
                    (ScmpW'(ram_rdata[SCORE_BITS-1:0]) < ScmpW'(thr_q));
  assign gap_len = (state_q == StLeft) ? (DistW'(first_q) - DistW'(pidx_q))
                                       : (DistW'(pidx_q) - DistW'(last_q));
  assign stop_hit  = pend_q & ent_fail & (gap_len >= DistW'(bases_q));
  assign scan_done = stop_hit | (!pend_q & !more_q);
  assign slot_free = !m_tvalid_q | m_tready;

  // ---------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    core_first_d = core_first_q;
    core_last_d  = core_last_q;
    sum_d        = sum_q;
    seen_d       = seen_q;
    len_d        = len_q;
    prod_d       = prod_q;
    first_d      = first_q;
    last_d       = last_q;
    addr_d       = addr_q;
    pidx_d       = pidx_q;
    more_d       = more_q;
    pend_d       = pend_q;
    m_tvalid_d   = m_tvalid_q & !m_tready;
    out_first_d  = out_first_q;
    out_last_d   = out_last_q;
    out_user_d   = out_user_q;

    unique case (state_q)
      StLoad: begin
        // Store the sample and track the core span and sum
        if (ram_we) begin
          if (in_core) begin
            if (!seen_q) begin
              core_first_d = cnt_q[IdxW-1:0];
            end
            core_last_d = cnt_q[IdxW-1:0];
            seen_d      = 1'b1;
            if (!in_missing) begin
              sum_d = sum_q + SumW'(in_score);
            end
          end
          cnt_d = cnt_q + 1'b1;
        end
        if (in_beat && s_tlast) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        len_d   = LenW'(core_last_q) - LenW'(core_first_q) + 1'b1;
        first_d = core_first_q;
        last_d  = core_last_q;
        state_d = seen_q ? StMul : StEmit;
      end
      StMul: begin
        // Form threshold times length; prime the left scan
        prod_d  = ProdW'(thr_q) * ProdW'(len_q);
        addr_d  = core_first_q - 1'b1;
        more_d  = (core_first_q != '0);
        pend_d  = 1'b0;
        state_d = StLeft;
      end
      StLeft, StRight: begin
        // Take the returned sample as a new outer pass
        if (pend_q && !ent_fail) begin
          if (state_q == StLeft) begin
            first_d = pidx_q;
          end else begin
            last_d = pidx_q;
          end
        end
        if (scan_done) begin
          pend_d = 1'b0;
          if (state_q == StLeft) begin
            addr_d  = core_last_q + 1'b1;
            more_d  = (CntW'(core_last_q) + 1'b1) < cnt_q;
            state_d = StRight;
          end else begin
            state_d = StEmit;
          end
        end else if (more_q) begin
          // Issue the next read outward
          pend_d = 1'b1;
          pidx_d = addr_q;
          if (state_q == StLeft) begin
            addr_d = addr_q - 1'b1;
            more_d = (addr_q != '0);
          end else begin
            addr_d = addr_q + 1'b1;
            more_d = (CntW'(addr_q) + 1'b1) < cnt_q;
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      StEmit: begin
        // Load the result beat and open a new window
        if (slot_free) begin
          m_tvalid_d    = 1'b1;
          out_first_d   = first_q;
          out_last_d    = last_q;
          out_user_d[0] = seen_q & (CmpW'(sum_q) < CmpW'(prod_q));
          out_user_d[1] = !seen_q;
          cnt_d         = '0;
          core_first_d  = '0;
          core_last_d   = '0;
          sum_d         = '0;
          seen_d        = 1'b0;
          state_d       = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      cnt_q        <= '0;
      core_first_q <= '0;
      core_last_q  <= '0;
      sum_q        <= '0;
      seen_q       <= 1'b0;
      more_q       <= 1'b0;
      pend_q       <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      core_first_q <= core_first_d;
      core_last_q  <= core_last_d;
      sum_q        <= sum_d;
      seen_q       <= seen_d;
      more_q       <= more_d;
      pend_q       <= pend_d;
      m_tvalid_q   <= m_tvalid_d;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    prod_q      <= prod_d;
    first_q     <= first_d;
    last_q      <= last_d;
    addr_q      <= addr_d;
    pidx_q      <= pidx_d;
    out_first_q <= out_first_d;
    out_last_q  <= out_last_d;
    out_user_q  <= out_user_d;
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = OutDataW'({out_last_q, out_first_q});
  assign m_tuser  = out_user_q;

  // ---------------------------------------------------------------------
  // Assertions
  a_plateau_covers_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && seen_q) |-> (first_q <= core_first_q && last_q >= core_last_q))
    else $error("plateau does not cover the core");

  a_read_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StLeft || state_q == StRight) && pend_q) |-> (CntW'(pidx_q) < cnt_q))
    else $error("scan read beyond the loaded window");

  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input accepted during evaluation");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(state_q == StEmit))
    else $error("result beat without an evaluation");

endmodule

@@ tb/plateau_checker.sv @@
// Scoreboard for the plateau region extender: follows APB writes and both
// streams, predicts the plateau of every window and checks each result beat.
// Depends on pre_pkg.
module plateau_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pre_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pre_pkg::ApbDataW-1:0]  pwdata,
  input  logic                          pready,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // score
  input  logic [1:0]                    s_tuser,   // missing, in_core
  input  logic                          s_tlast,   // last_sample
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [31:0]                   m_tdata,   // plateau_first, plateau_last
  input  logic [1:0]                    m_tuser,   // core_below_threshold, no_core
  output int                            fail_count,
  output int                            results_pending
);

  localparam int unsigned WinDepth = pre_pkg::MaxWindowDef;
  localparam int unsigned IdxW     = $clog2(WinDepth);
  localparam int unsigned ScoreW   = pre_pkg::ScoreBitsDef;

  typedef struct packed {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
    logic            below;
    logic            no_core;
  } plateau_t;

  // Window image: score plus missing flag in the top bit
  bit [ScoreW:0]              win_store [WinDepth];
  int unsigned                win_count;
  int unsigned                core_lo;
  int unsigned                core_hi;
  longint unsigned            core_sum;
  bit                         core_found;
  bit [pre_pkg::ThrW-1:0]     thr_q;
  bit [pre_pkg::BasesW-1:0]   bases_q;
  plateau_t                   plateau_q [$];
  plateau_t                   seen_res;
  plateau_t                   want_res;

  initial begin
    fail_count      = 0;
    results_pending = 0;
  end

  function automatic void clear_window();
    win_count  = 0;
    core_lo    = 0;
    core_hi    = 0;
    core_sum   = 0;
    core_found = 1'b0;
  endfunction

  // A sample counts toward a failing run if it is missing or scores under the threshold
  function automatic bit sample_drops(int unsigned idx);
    return win_store[idx][ScoreW] || (win_store[idx][ScoreW-1:0] < thr_q);
  endfunction

  function automatic plateau_t predict_plateau();
    plateau_t        res;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     i;
    longint unsigned span;
    res = '0;
    if (!core_found) begin
      res.no_core = 1'b1;
      return res;
    end
    // average check without division: sum against threshold times length
    span      = core_hi - core_lo + 1;
    res.below = core_sum < 64'(thr_q) * span;
    // grow left until the failing run reaches the drop length
    lo = core_lo;
    i  = core_lo;
    while (i > 0) begin
      i--;
      if (!sample_drops(i)) lo = i;
      else if (lo - i >= bases_q) break;
    end
    // grow right the same way, bounded by the stored samples
    hi = core_hi;
    for (i = core_hi + 1; i < win_count; i++) begin
      if (!sample_drops(i)) hi = i;
      else if (i - hi >= bases_q) break;
    end
    res.first = lo[IdxW-1:0];
    res.last  = hi[IdxW-1:0];
    return res;
  endfunction

  task automatic flag_field(input string name, input logic [IdxW-1:0] want,
                            input logic [IdxW-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   = pre_pkg::ThrReset;
      bases_q = pre_pkg::BasesReset;
      clear_window();
      plateau_q.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[pre_pkg::ApbAddrW-1:2] == pre_pkg::RegDropThreshold) begin
          thr_q = pwdata[pre_pkg::ThrW-1:0];
        end else if (paddr[pre_pkg::ApbAddrW-1:2] == pre_pkg::RegDropBases) begin
          bases_q = pwdata[pre_pkg::BasesW-1:0];
        end
      end
      // check a result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        seen_res.first   = m_tdata[IdxW-1:0];
        seen_res.last    = m_tdata[2*IdxW-1:IdxW];
        seen_res.below   = m_tuser[0];
        seen_res.no_core = m_tuser[1];
        if (plateau_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, %s%0d %s%0d %s%0b %s%0b",
                   $time, "actual first=", seen_res.first, "last=", seen_res.last,
                   "below=", seen_res.below, "no_core=", seen_res.no_core);
          fail_count++;
        end else begin
          want_res = plateau_q.pop_front();
          flag_field("plateau_first", want_res.first, seen_res.first);
          flag_field("plateau_last", want_res.last, seen_res.last);
          flag_field("core_below_threshold", IdxW'(want_res.below),
                     IdxW'(seen_res.below));
          flag_field("no_core", IdxW'(want_res.no_core), IdxW'(seen_res.no_core));
        end
      end
      // absorb a sample beat; beats past capacity are dropped
      if (s_tvalid && s_tready) begin
        if (win_count < WinDepth) begin
          win_store[win_count] = {s_tuser[0], s_tdata[ScoreW-1:0]};
          if (s_tuser[1]) begin
            if (!core_found) core_lo = win_count;
            core_hi    = win_count;
            core_found = 1'b1;
            if (!s_tuser[0]) core_sum += 64'(s_tdata[ScoreW-1:0]);
          end
          win_count++;
        end
        if (s_tlast) begin
          plateau_q.push_back(predict_plateau());
          clear_window();
        end
      end
    end
    results_pending = plateau_q.size();
  end

endmodule

@@ tb/tb_plateau_region_extender.sv @@
// Testbench top for the plateau region extender: clock, reset, APB setup and
// sample windows with random idling on both streams. Uses pre_pkg,
// plateau_region_extender and plateau_checker.
module tb_plateau_region_extender;

  localparam int unsigned RandomItems = 1400;
  localparam int unsigned PhaseItems  = RandomItems / 6;
  localparam int unsigned QuietLimit  = 200000;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [pre_pkg::ApbAddrW-1:0]  paddr    = '0;
  logic [pre_pkg::ApbDataW-1:0]  pwdata   = '0;
  logic [pre_pkg::ApbDataW-1:0]  prdata;
  logic                          pready;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata  = '0;   // score
  logic [1:0]                    s_tuser  = '0;   // missing, in_core
  logic                          s_tlast  = 1'b0; // last_sample
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;         // plateau_first, plateau_last
  logic [1:0]                    m_tuser;         // core_below_threshold, no_core

  int          fail_count;
  int          results_pending;
  int unsigned thr_set      = pre_pkg::ThrReset;
  int unsigned samples_sent = 0;
  int unsigned windows_sent = 0;
  int unsigned settings     = 1;
  int unsigned quiet_cycles = 0;
  int unsigned rx_stall     = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;

  plateau_region_extender u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  plateau_checker u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .results_pending
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure unless in a steady stretch
  always @(negedge clk_i) begin
    if (rx_stall != 0) begin
      m_tready = 1'b0;
      rx_stall--;
    end else begin
      m_tready = 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 30) rx_stall = idle_len();
    end
  end

  // Abort when neither stream nor the register port moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(input bit [15:0] score, input bit miss, input bit core,
                           input bit last);
    int unsigned gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = score;
    s_tuser  = {core, miss};
    s_tlast  = last;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    samples_sent++;
    if (last) windows_sent++;
  endtask

  // Score biased around the threshold: {missing, score}
  function automatic bit [16:0] pick_sample(int unsigned pass_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return {1'b0, 16'(thr_set)};
    if (r < 6 && thr_set != 0) return {1'b0, 16'(thr_set - 1)};
    if ($urandom_range(0, 99) < pass_pct) return {1'b0, 16'($urandom_range(thr_set, 32768))};
    if (thr_set == 0 || $urandom_range(0, 4) == 0) return {1'b1, 16'($urandom_range(0, 32768))};
    return {1'b0, 16'($urandom_range(0, thr_set - 1))};
  endfunction

  // One window: usually a contiguous core, sometimes scattered, none, or noise
  task automatic send_window(int unsigned len);
    int unsigned r;
    int unsigned core_at;
    int unsigned core_n;
    int unsigned pass_pct;
    int unsigned k;
    bit          has_core;
    bit          noisy;
    bit          scatter;
    bit          flag;
    bit [16:0]   smp;
    r        = $urandom_range(0, 99);
    has_core = (r >= 8);
    noisy    = (r >= 8 && r < 18);
    scatter  = (r >= 18 && r < 32);
    core_at  = $urandom_range(0, len - 1);
    core_n   = $urandom_range(1, (len - core_at < 10) ? len - core_at : 10);
    pass_pct = $urandom_range(20, 95);
    for (k = 0; k < len; k++) begin
      if (noisy) begin
        smp[15:0] = 16'($urandom_range(0, 32768));
        smp[16]   = ($urandom_range(0, 7) == 0);
        flag      = ($urandom_range(0, 3) == 0);
      end else begin
        smp  = pick_sample(pass_pct);
        flag = has_core && k >= core_at && k < core_at + core_n &&
               (!scatter || k == core_at || k == core_at + core_n - 1 ||
                $urandom_range(0, 1) == 1);
      end
      send_beat(smp[15:0], smp[16], flag, k == len - 1);
    end
  endtask

  // Hold the sender until every window result is back, then settle
  task automatic drain();
    s_tvalid = 1'b0;
    wait (results_pending == 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_reg(input logic [pre_pkg::ApbAddrW-1:0] addr,
                             input logic [pre_pkg::ApbDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_setting(int unsigned thr, int unsigned bases);
    drain();
    program_reg({pre_pkg::RegDropThreshold, 2'b00}, thr);
    program_reg({pre_pkg::RegDropBases, 2'b00}, bases);
    thr_set = thr;
    settings++;
  endtask

  task automatic random_windows(int unsigned quota);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      tx_steady = ($urandom_range(0, 7) == 0);
      rx_steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 16);
      else if (r < 99) len = $urandom_range(17, 80);
      else len = $urandom_range(200, 600);
      send_window(len);
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed windows at reset settings
    // no core at all
    send_beat(16'd100, 1'b0, 1'b0, 1'b0);
    send_beat(16'd32768, 1'b1, 1'b0, 1'b1);
    // single full-scale core sample, then a single missing core sample
    send_beat(16'd32768, 1'b0, 1'b1, 1'b1);
    send_beat(16'd0, 1'b1, 1'b1, 1'b1);
    // scattered core with a gap, growth across short failing runs
    send_beat(16'd30000, 1'b0, 1'b0, 1'b0);
    send_beat(16'd0, 1'b0, 1'b0, 1'b0);
    send_beat(16'd32768, 1'b0, 1'b1, 1'b0);
    send_beat(16'd30000, 1'b0, 1'b0, 1'b0);
    send_beat(16'd5000, 1'b1, 1'b1, 1'b0);
    send_beat(16'(pre_pkg::ThrReset), 1'b0, 1'b0, 1'b0);
    send_beat(16'd30000, 1'b1, 1'b0, 1'b1);
    // failing runs of exactly the drop length stop growth on both sides
    send_beat(16'd30000, 1'b0, 1'b0, 1'b0);
    repeat (5) send_beat(16'(pre_pkg::ThrReset - 1), 1'b0, 1'b0, 1'b0);
    send_beat(16'd32768, 1'b0, 1'b1, 1'b0);
    repeat (5) send_beat(16'd1000, 1'b0, 1'b0, 1'b0);
    send_beat(16'd30000, 1'b0, 1'b0, 1'b1);
    random_windows(PhaseItems);

    apply_setting(0, 1);
    random_windows(PhaseItems);
    apply_setting(32768, 4096);
    random_windows(PhaseItems);
    // a zero drop length behaves like one
    apply_setting(16384, 0);
    random_windows(PhaseItems);

    apply_setting(20000, 3);
    random_windows(PhaseItems);

    apply_setting($urandom_range(0, 32768), $urandom_range(1, 64));
    random_windows(PhaseItems);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d samples in %0d windows under %0d register settings,",
             samples_sent, windows_sent, settings);
    $display("thresholds 0 to full scale, drop lengths 0 to 4096, cores absent to scattered.");
    if (fail_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
